// File: hw/rtl/gbp_pkg.sv
// Package for the gshare branch predictor: widths, register indexes,
// counter codes, the configuration struct and the counter update function.
// No dependencies.
package gbp_pkg;

    localparam int MAX_INDEX_BITS_DEF = 12;
    localparam int PC_W               = 32;
    localparam int COUNT_W            = 32;
    localparam int HIST_W             = 12;
    localparam int CFG_W              = 4;
    localparam int CFG_IDX_W          = 1;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INDEX_BITS   = 1'b0,
        REG_HISTORY_BITS = 1'b1
    } cfg_reg_t;

    localparam logic [CFG_W-1:0] INDEX_BITS_RESET   = 4'd10;
    localparam logic [CFG_W-1:0] HISTORY_BITS_RESET = 4'd8;

    // 2-bit saturating counter codes
    typedef logic [1:0] ctr_t;
    localparam ctr_t CTR_STRONG_NT = 2'd0;
    localparam ctr_t CTR_WEAK_NT   = 2'd1;
    localparam ctr_t CTR_WEAK_T    = 2'd2;
    localparam ctr_t CTR_STRONG_T  = 2'd3;

    typedef struct packed {
        logic [CFG_W-1:0] index_bits;
        logic [CFG_W-1:0] history_bits;
    } gbp_cfg_t;

    // step one counter toward the resolved outcome, saturating
    function automatic ctr_t ctr_update(ctr_t ctr, logic taken);
        ctr_t res;
        res = ctr;
        if (taken)
        begin
            if (ctr != CTR_STRONG_T)
                res = ctr + 2'd1;
        end
        else
        begin
            if (ctr != CTR_STRONG_NT)
                res = ctr - 2'd1;
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/gbp_branch_if.sv
// Input channel of the predictor: one resolved branch per word.
// Depends on gbp_pkg.
interface gbp_branch_if;
    import gbp_pkg::*;

    logic            valid;
    logic            ready;
    logic [PC_W-1:0] branch_pc;
    logic            actual_taken;

    modport source (output valid, branch_pc, actual_taken, input ready);
    modport sink   (input valid, branch_pc, actual_taken, output ready);
endinterface

// File: hw/rtl/gbp_result_if.sv
// Output channel of the predictor: prediction, mispredict flag and counts.
// Depends on gbp_pkg.
interface gbp_result_if;
    import gbp_pkg::*;

    logic               valid;
    logic               ready;
    logic               predicted_taken;
    logic               mispredicted;
    logic [COUNT_W-1:0] branch_count;
    logic [COUNT_W-1:0] mispredict_count;

    modport source (output valid, predicted_taken, mispredicted, branch_count,
                    mispredict_count, input ready);
    modport sink   (input valid, predicted_taken, mispredicted, branch_count,
                    mispredict_count, output ready);
endinterface

// File: hw/rtl/gbp_counter_ram.sv
// Counter table: one write port, one read port, registered read data.
// Depends on gbp_pkg.
module gbp_counter_ram #(
    parameter int IDX_W = gbp_pkg::MAX_INDEX_BITS_DEF
) (
    input  logic             clk,
    input  logic             we,
    input  logic [IDX_W-1:0] waddr,
    input  gbp_pkg::ctr_t    wdata,
    input  logic             re,
    input  logic [IDX_W-1:0] raddr,
    output gbp_pkg::ctr_t    rdata
);
    import gbp_pkg::*;

    localparam int DEPTH = 1 << IDX_W;

    ctr_t mem [DEPTH];
    ctr_t rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    // read port, old data on a same-address collision
    always_ff @(posedge clk)
    begin
        if (re)
            rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// File: hw/rtl/gbp_index_unit.sv
// Table index and next global history for one branch.
// Depends on gbp_pkg.
module gbp_index_unit #(
    parameter int IDX_W = gbp_pkg::MAX_INDEX_BITS_DEF
) (
    input  gbp_pkg::gbp_cfg_t            cfg,
    input  logic [gbp_pkg::PC_W-1:0]     branch_pc,
    input  logic                         actual_taken,
    input  logic [gbp_pkg::HIST_W-1:0]   hist,
    output logic [IDX_W-1:0]             idx,
    output logic [gbp_pkg::HIST_W-1:0]   hist_next
);
    import gbp_pkg::*;

    localparam int SW  = (IDX_W > HIST_W) ? IDX_W : HIST_W;
    localparam int NHW = HIST_W + CFG_W;
    localparam logic [4:0] MAXB = 5'(IDX_W);

    logic [CFG_W-1:0]  m;
    logic [CFG_W-1:0]  n;
    logic [IDX_W-1:0]  mmask;
    logic [HIST_W-1:0] hist_m;
    logic [SW-1:0]     hist_sh;
    logic [NHW-1:0]    nh;

    // effective index and history lengths
    always_comb
    begin
        if (cfg.index_bits == '0)
            m = CFG_W'(1);
        else if (5'(cfg.index_bits) > MAXB)
            m = MAXB[CFG_W-1:0];
        else
            m = cfg.index_bits;
        n = (cfg.history_bits < m) ? cfg.history_bits : m;
    end

    // index: PC bits XOR history aligned to the top of the index
    always_comb
    begin
        mmask   = ~({IDX_W{1'b1}} << m);
        hist_m  = hist & ~({HIST_W{1'b1}} << n);
        hist_sh = SW'(hist_m) << (m - n);
        idx     = (branch_pc[IDX_W+1:2] ^ hist_sh[IDX_W-1:0]) & mmask;
    end

    // history shifts right, outcome enters at bit n-1
    always_comb
    begin
        nh = (NHW'(hist_m) >> 1) | (NHW'(actual_taken) << (n - CFG_W'(1)));
        if (n == '0)
            hist_next = '0;
        else
            hist_next = nh[HIST_W-1:0];
    end
endmodule

// File: hw/rtl/gshare_branch_predictor.sv
// gshare predictor with 2-bit counters. Takes one resolved branch per cycle
// outside the clearing pass and while the output side does not stall; its
// result passes through the update stage into the output register. The
// counter table is a RAM with registered read data: the counter is read when
// the branch is accepted and written back when the branch leaves the update
// stage, and a branch accepted while its entry is being written gets the new
// value forwarded. History is updated at acceptance, so dependent branches
// need no stall. After reset a clearing pass sets every counter to weakly
// taken; no branch is accepted until it ends, while configuration writes are taken at any time.
module gshare_branch_predictor #(
    parameter int MAX_INDEX_BITS = gbp_pkg::MAX_INDEX_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [gbp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [gbp_pkg::CFG_W-1:0]   cfg_data,
    gbp_branch_if.sink                  branch,
    gbp_result_if.source                result
);
    import gbp_pkg::*;

    localparam int IDX_W = MAX_INDEX_BITS;

    gbp_cfg_t           cfg_reg;
    logic [HIST_W-1:0]  hist_reg;
    logic [HIST_W-1:0]  hist_next;
    logic [IDX_W-1:0]   idx;

    logic               clr_active_reg;
    logic [IDX_W-1:0]   clr_addr_reg;

    logic               s1_valid_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic               s1_taken_reg;
    logic               s1_fwd_reg;
    ctr_t               s1_fwd_ctr_reg;

    logic               out_valid_reg;
    logic               out_pred_reg;
    logic               out_miss_reg;
    logic [COUNT_W-1:0] seen_reg;
    logic [COUNT_W-1:0] missed_reg;
    logic [COUNT_W-1:0] seen_next;
    logic [COUNT_W-1:0] missed_next;

    logic               out_free;
    logic               s1_adv;
    logic               in_acc;
    ctr_t               rdata;
    ctr_t               ctr_cur;
    ctr_t               ctr_new;
    logic               pred;
    logic               miss;
    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    ctr_t               ram_wdata;

    // handshake
    assign out_free     = !out_valid_reg || result.ready;
    assign s1_adv       = s1_valid_reg && out_free;
    assign branch.ready = !clr_active_reg && (!s1_valid_reg || out_free);
    assign in_acc       = branch.valid && branch.ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.index_bits   <= INDEX_BITS_RESET;
            cfg_reg.history_bits <= HISTORY_BITS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_INDEX_BITS:   cfg_reg.index_bits   <= cfg_data;
                REG_HISTORY_BITS: cfg_reg.history_bits <= cfg_data;
                default:          ;
            endcase
        end
    end

    gbp_index_unit #(
        .IDX_W (IDX_W)
    ) u_index (
        .cfg          (cfg_reg),
        .branch_pc    (branch.branch_pc),
        .actual_taken (branch.actual_taken),
        .hist         (hist_reg),
        .idx          (idx),
        .hist_next    (hist_next)
    );

    // global history advances at acceptance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hist_reg <= '0;
        else if (in_acc)
            hist_reg <= hist_next;
    end

    // clearing pass after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + IDX_W'(1);
            if (clr_addr_reg == '1)
                clr_active_reg <= 1'b0;
        end
    end

    // RAM write port: clearing pass or write-back
    always_comb
    begin
        if (clr_active_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = CTR_WEAK_T;
        end
        else
        begin
            ram_we    = s1_adv;
            ram_waddr = s1_idx_reg;
            ram_wdata = ctr_new;
        end
    end

    gbp_counter_ram #(
        .IDX_W (IDX_W)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (in_acc),
        .raddr (idx),
        .rdata (rdata)
    );

    // update stage: counter with forwarding, prediction, new counter
    always_comb
    begin
        ctr_cur = s1_fwd_reg ? s1_fwd_ctr_reg : rdata;
        pred    = ctr_cur[1];
        miss    = pred ^ s1_taken_reg;
        ctr_new = ctr_update(ctr_cur, s1_taken_reg);
    end

    // update stage registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_acc)
            s1_valid_reg <= 1'b1;
        else if (s1_adv)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_idx_reg     <= idx;
            s1_taken_reg   <= branch.actual_taken;
            s1_fwd_reg     <= s1_adv && (idx == s1_idx_reg);
            s1_fwd_ctr_reg <= ctr_new;
        end
    end

    // saturating counts
    always_comb
    begin
        seen_next   = (seen_reg == '1) ? seen_reg : seen_reg + COUNT_W'(1);
        missed_next = (miss && missed_reg != '1) ? missed_reg + COUNT_W'(1)
                                                 : missed_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg   <= '0;
            missed_reg <= '0;
        end
        else if (s1_adv)
        begin
            seen_reg   <= seen_next;
            missed_reg <= missed_next;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_adv)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_pred_reg <= pred;
            out_miss_reg <= miss;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.predicted_taken  = out_pred_reg;
    assign result.mispredicted     = out_miss_reg;
    assign result.branch_count     = seen_reg;
    assign result.mispredict_count = missed_reg;

    // no branch enters while the table is being cleared
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> !branch.ready)
        else $error("branch accepted during clearing pass");

    // mispredictions never outnumber branches
    a_counts_ordered: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (missed_reg <= seen_reg))
        else $error("mispredict count exceeds branch count");

    // a stalled update stage keeps its entry and issues no write
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !out_free) |=> (s1_valid_reg && $stable(s1_idx_reg)))
        else $error("update stage lost its branch while stalled");

    // the counts move only with a new result
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> $stable(seen_reg))
        else $error("branch count changed without a result");
endmodule

// File: tb/sv/tb_top.sv
// Self-checking bench for gshare_branch_predictor: random and directed branch
// streams, a software model of the counter table in a small scoreboard class.
// Depends on gbp_pkg, gbp_branch_if, gbp_result_if and the predictor RTL.
module tb_top;
    import gbp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_DEPTH = 1 << MAX_INDEX_BITS_DEF;
    localparam int REPORT_MAX  = 10;

    // one predicted result word
    typedef struct packed {
        logic               taken_guess;
        logic               miss;
        logic [COUNT_W-1:0] seen;
        logic [COUNT_W-1:0] missed;
    } verdict_t;

    // gshare model: counter table, history, running counts, register copies
    class branch_scoreboard;
        ctr_t             counters [TABLE_DEPTH];
        logic [HIST_W-1:0] ghist;
        logic [COUNT_W-1:0] seen_cnt;
        logic [COUNT_W-1:0] miss_cnt;
        logic [CFG_W-1:0]  index_reg;
        logic [CFG_W-1:0]  hist_reg;
        verdict_t          pending [$];
        int                errors;

        function new();
            foreach (counters[i])
                counters[i] = CTR_WEAK_T;
            ghist     = '0;
            seen_cnt  = '0;
            miss_cnt  = '0;
            index_reg = INDEX_BITS_RESET;
            hist_reg  = HISTORY_BITS_RESET;
            errors    = 0;
        endfunction

        function void set_reg(cfg_reg_t sel, logic [CFG_W-1:0] val);
            if (sel == REG_INDEX_BITS)
                index_reg = val;
            else
                hist_reg = val;
        endfunction

        // accepted branch: predict, train the counter, shift the history
        function void note_branch(logic [PC_W-1:0] pc, logic taken);
            int unsigned m;
            int unsigned n;
            logic [31:0] mmask;
            logic [31:0] hist;
            logic [31:0] slot;
            ctr_t        ctr;
            verdict_t    v;
            m = index_reg;
            if (m < 1)
                m = 1;
            if (m > MAX_INDEX_BITS_DEF)
                m = MAX_INDEX_BITS_DEF;
            n = (hist_reg < m) ? hist_reg : m;
            mmask = (32'd1 << m) - 32'd1;
            hist = 32'(ghist) & ((32'd1 << n) - 32'd1);
            slot = (((pc >> 2) & mmask) ^ (hist << (m - n))) & mmask;
            ctr = counters[slot[MAX_INDEX_BITS_DEF-1:0]];
            v.taken_guess = (ctr == CTR_WEAK_T || ctr == CTR_STRONG_T);
            v.miss = v.taken_guess ^ taken;
            if (taken)
            begin
                if (ctr != CTR_STRONG_T)
                    ctr = ctr + 2'd1;
            end
            else
            begin
                if (ctr != CTR_STRONG_NT)
                    ctr = ctr - 2'd1;
            end
            counters[slot[MAX_INDEX_BITS_DEF-1:0]] = ctr;
            if (n > 0)
                hist = (hist >> 1) | (32'(taken) << (n - 1));
            else
                hist = '0;
            ghist = hist[HIST_W-1:0];
            if (seen_cnt != '1)
                seen_cnt = seen_cnt + 1'b1;
            if (v.miss && miss_cnt != '1)
                miss_cnt = miss_cnt + 1'b1;
            v.seen   = seen_cnt;
            v.missed = miss_cnt;
            pending.push_back(v);
        endfunction

        // compare one result word against the oldest prediction
        function void check_result(verdict_t got);
            verdict_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: result word with no branch pending: %p", $realtime, got);
                return;
            end
            want = pending.pop_front();
            if (got.taken_guess !== want.taken_guess || got.miss !== want.miss ||
                got.seen !== want.seen || got.missed !== want.missed)
            begin
                errors++;
                if (errors <= REPORT_MAX)
                    $display("%0t: mismatch pred %0b/%0b miss %0b/%0b cnt %0d/%0d miss_cnt %0d/%0d",
                             $realtime, want.taken_guess, got.taken_guess, want.miss, got.miss,
                             want.seen, got.seen, want.missed, got.missed);
            end
        endfunction
    endclass

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_data;
    int               idle_pct;

    gbp_branch_if br_if ();
    gbp_result_if res_if ();

    branch_scoreboard sb = new();

    gshare_branch_predictor u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .branch    (br_if),
        .result    (res_if)
    );

    // 50 MHz clock
    initial
        clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // known values on every input from time zero
    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = REG_INDEX_BITS;
        cfg_data           = '0;
        br_if.valid        = 1'b0;
        br_if.branch_pc    = '0;
        br_if.actual_taken = 1'b0;
        res_if.ready       = 1'b0;
        idle_pct           = 23;
    end

    function automatic bit idle_now();
        return $urandom_range(99) < idle_pct;
    endfunction

    // result side: check accepted words, stall at random
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result({res_if.predicted_taken, res_if.mispredicted,
                             res_if.branch_count, res_if.mispredict_count});
        res_if.ready <= rst_n && !idle_now();
    end

    // drive one branch word and hold it until taken
    task automatic send_branch(logic [PC_W-1:0] pc, logic taken);
        while (idle_now())
        begin
            br_if.valid <= 1'b0;
            @(posedge clk);
        end
        br_if.valid        <= 1'b1;
        br_if.branch_pc    <= pc;
        br_if.actual_taken <= taken;
        do
            @(posedge clk);
        while (!(br_if.valid && br_if.ready));
        sb.note_branch(pc, taken);
    endtask

    // stop sending and wait for every pending result word
    task automatic drain();
        br_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    // write both registers on back-to-back cycles
    task automatic write_regs(logic [CFG_W-1:0] ib, logic [CFG_W-1:0] hb);
        cfg_we    <= 1'b1;
        cfg_index <= REG_INDEX_BITS;
        cfg_data  <= ib;
        @(posedge clk);
        cfg_index <= REG_HISTORY_BITS;
        cfg_data  <= hb;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.set_reg(REG_INDEX_BITS, ib);
        sb.set_reg(REG_HISTORY_BITS, hb);
    endtask

    // run one phase of random traffic: mostly loop branches, some noise
    task automatic random_phase(int count, bit mid_drain);
        logic [PC_W-1:0] pool [8];
        int              trip [8];
        int              iter [8];
        int              k;
        foreach (pool[i])
        begin
            pool[i] = $urandom;
            trip[i] = $urandom_range(9, 2);
            iter[i] = 0;
        end
        for (int j = 0; j < count; j++)
        begin
            if (mid_drain && j == count / 2)
                drain();
            if ($urandom_range(99) < 75)
            begin
                k = $urandom_range(7);
                send_branch(pool[k], (iter[k] % trip[k]) != trip[k] - 1);
                iter[k]++;
            end
            else
                send_branch($urandom, $urandom_range(1));
        end
    endtask

    // stimulus
    initial
    begin
        logic [CFG_W-1:0] idx_set [9];
        logic [CFG_W-1:0] his_set [9];
        idx_set = '{4'd12, 4'd1, 4'd5, 4'd15, 4'd10, 4'd7, 4'd3, 4'd0, 4'd0};
        his_set = '{4'd12, 4'd12, 4'd0, 4'd3, 4'd8, 4'd7, 4'd15, 4'd9, 4'd0};
        idx_set[8] = $urandom_range(15);
        his_set[8] = $urandom_range(15);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: saturate one counter toward not taken, then PC field extremes
        repeat (3) send_branch(32'h0000_0000, 1'b0);
        repeat (3) send_branch(32'h0000_0000, 1'b1);
        send_branch(32'hFFFF_FFFF, 1'b1);
        send_branch(32'hFFFF_FFFC, 1'b0);
        send_branch(32'h0000_0003, 1'b1);
        send_branch(32'hAAAA_AAAA, 1'b0);
        send_branch(32'h5555_5555, 1'b1);

        // index width zero is used as one, no history
        drain();
        write_regs(4'd0, 4'd0);
        send_branch(32'h0000_0000, 1'b1);
        send_branch(32'h0000_0004, 1'b0);
        send_branch(32'h0000_0000, 1'b1);
        send_branch(32'hFFFF_FFFF, 1'b0);

        // oversized index and history clamp to the table width
        drain();
        write_regs(4'd15, 4'd15);
        repeat (2) send_branch(32'hFFFF_FFFF, 1'b1);
        send_branch(32'h0000_0000, 1'b0);
        send_branch(32'h1234_5678, 1'b1);
        send_branch(32'h8000_0000, 1'b0);

        // random phases; phase 4 runs with no idling on either side
        for (int p = 0; p < 9; p++)
        begin
            drain();
            write_regs(idx_set[p], his_set[p]);
            idle_pct = (p == 4) ? 0 : 23;
            random_phase(200, p == 2);
        end

        drain();
        repeat (8) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #4_000_000;
        $display("tb_top: errors");
        $finish;
    end

endmodule

// File: filelist.f
hw/rtl/gbp_pkg.sv
hw/rtl/gbp_branch_if.sv
hw/rtl/gbp_result_if.sv
hw/rtl/gbp_counter_ram.sv
hw/rtl/gbp_index_unit.sv
hw/rtl/gshare_branch_predictor.sv
tb/sv/tb_top.sv
